// File: rtl/apd_pkg.sv
// ----------------------------------------------------------------------------
// apd_pkg
// Shared types, widths and constants of the average pooling downsampler.
// ----------------------------------------------------------------------------
package apd_pkg;

  // payload widths
  localparam int SAMPLE_W = 8;
  localparam int AVG_W    = 8;
  localparam int SUM_W    = 16;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam int WIDTH_REG_W   = 13;
  localparam int HEIGHT_REG_W  = 13;
  localparam int CHANNEL_REG_W = 3;
  localparam int FACTOR_REG_W  = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_POOL_FACTOR   = 2'd3
  } cfg_reg_t;

  localparam logic [WIDTH_REG_W-1:0]   RST_FRAME_WIDTH   = 13'd640;
  localparam logic [HEIGHT_REG_W-1:0]  RST_FRAME_HEIGHT  = 13'd480;
  localparam logic [CHANNEL_REG_W-1:0] RST_CHANNEL_COUNT = 3'd3;
  localparam logic [FACTOR_REG_W-1:0]  RST_POOL_FACTOR   = 5'd2;

  // default sizing
  localparam int DEF_MAX_WIDTH    = 4096;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_MAX_FACTOR   = 16;

  // reciprocal table: ceil(2^24 / (f*f)) for f = 1..16, indexed by f-1.
  // Exact floor division for every 16-bit sum.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 25;
  localparam int RECIP_IDX_W = 4;

  localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
    25'd16777216, 25'd4194304, 25'd1864136, 25'd1048576,
    25'd671089,   25'd466034,  25'd342393,  25'd262144,
    25'd207127,   25'd167773,  25'd138655,  25'd116509,
    25'd99274,    25'd85599,   25'd74566,   25'd65536
  };

endpackage

// File: rtl/apd_stream_if.sv
// ----------------------------------------------------------------------------
// apd_sample_if / apd_result_if
// Valid/ready channels for input samples and pooled results.
// ----------------------------------------------------------------------------
interface apd_sample_if;
  import apd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface apd_result_if;
  import apd_pkg::*;

  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] average;
  logic             frame_done;

  modport source (output valid, output average, output frame_done, input ready);
  modport sink   (input valid, input average, input frame_done, output ready);
endinterface

// File: rtl/apd_ram.sv
// ----------------------------------------------------------------------------
// apd_ram
// Simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module apd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/average_pool_downsample_core.sv
// ----------------------------------------------------------------------------
// average_pool_downsample_core
// Box-filter downsampler: averages factor x factor blocks per channel.
//
// Usage:
//   samples : one channel byte per beat, raster order, channels interleaved.
//   results : one averaged byte per beat, raster order of the output image;
//             frame_done marks the last result of a frame.
//   cfg     : cfg_write/cfg_index/cfg_data; any write restarts the frame.
//             Write only while the pipeline is empty.
// Throughput is one sample per cycle unless results stalls: each sample
// does one read and one write of the running-sum RAM, with the last written
// sum forwarded so that back-to-back updates of the same column hit.
// The beat that completes a block yields its result through the RAM read,
// the sum update and the reciprocal multiply into the output register.
// Reset restores the default geometry (640x480, 3 channels, factor 2) and
// zeroes the position counters. The sum RAM is not cleared: the first sample
// of every block overwrites its entry, so no clearing pass is needed.
// When results stalls, samples are still taken until every pipeline stage holds valid data; then ready drops.
// ----------------------------------------------------------------------------
module average_pool_downsample_core #(
  parameter int MAX_WIDTH    = apd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = apd_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_FACTOR   = apd_pkg::DEF_MAX_FACTOR
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [apd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [apd_pkg::CFG_DATA_W-1:0]  cfg_data,
  apd_sample_if.sink                     samples,
  apd_result_if.source                   results
);
  import apd_pkg::*;

  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_WIDTH + 2 * MAX_FACTOR) + 1;
  localparam int FW    = $clog2(MAX_FACTOR + 1);
  localparam int XFW   = $clog2(MAX_FACTOR);
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCW   = $clog2(MAX_CHANNELS + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = SUM_W + RECIP_W;

  // configuration registers
  logic [WIDTH_REG_W-1:0]   frame_width;
  logic [HEIGHT_REG_W-1:0]  frame_height;
  logic [CHANNEL_REG_W-1:0] channel_count;
  logic [FACTOR_REG_W-1:0]  pool_factor;

  logic [CW-1:0]  w_eff;
  logic [CW-1:0]  h_eff;
  logic [FW-1:0]  f_eff;
  logic [NCW-1:0] nc_eff;
  logic [CW-1:0]  f_cw;
  logic [XFW-1:0] f_last;

  // position counters
  logic [COLW-1:0] column_pos;
  logic [COLW-1:0] row_pos;
  logic [CHW-1:0]  channel_pos;
  logic [XFW-1:0]  col_phase;
  logic [XFW-1:0]  row_phase;
  logic [COLW-1:0] block_col;
  logic [CW-1:0]   col_base;
  logic [CW-1:0]   row_base;

  logic ch_wrap;
  logic col_wrap;
  logic row_wrap;
  logic col_phase_wrap;
  logic row_phase_wrap;
  logic in_block;
  logic blk_first;
  logic blk_last;
  logic frame_last;
  logic [AW-1:0] addr0;

  // pipeline
  logic                accept;
  logic                s1_free;
  logic                s2_free;
  logic                s3_free;
  logic                s1_move;

  logic                v1;
  logic [AW-1:0]       addr1;
  logic [SAMPLE_W-1:0] sample1;
  logic                first1;
  logic                last1;
  logic                done1;

  logic                v2;
  logic [SUM_W-1:0]    sum2;
  logic                done2;

  logic                v3;
  logic [AVG_W-1:0]    avg3;
  logic                done3;

  logic                lw_valid;
  logic [AW-1:0]       lw_addr;
  logic [SUM_W-1:0]    lw_sum;

  logic [SUM_W-1:0]    rd_data;
  logic [SUM_W-1:0]    base;
  logic [SUM_W-1:0]    sum1;
  logic [PW-1:0]       prod;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
      channel_count <= RST_CHANNEL_COUNT;
      pool_factor   <= RST_POOL_FACTOR;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[WIDTH_REG_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[HEIGHT_REG_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CHANNEL_REG_W-1:0];
        REG_POOL_FACTOR:   pool_factor   <= cfg_data[FACTOR_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (frame_width == '0) begin
      w_eff = CW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end

    if (frame_height == '0) begin
      h_eff = CW'(1);
    end else if (32'(frame_height) > MAX_WIDTH) begin
      h_eff = CW'(MAX_WIDTH);
    end else begin
      h_eff = CW'(frame_height);
    end

    if (channel_count == '0) begin
      nc_eff = NCW'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      nc_eff = NCW'(MAX_CHANNELS);
    end else begin
      nc_eff = NCW'(channel_count);
    end

    if (pool_factor == '0) begin
      f_eff = FW'(1);
    end else if (32'(pool_factor) > MAX_FACTOR) begin
      f_eff = FW'(MAX_FACTOR);
    end else begin
      f_eff = FW'(pool_factor);
    end
  end

  assign f_cw   = CW'(f_eff);
  assign f_last = XFW'(f_eff - FW'(1));

  // --------------------------------------------------------------------------
  // position tracking; block bases replace the divisions by the factor
  // --------------------------------------------------------------------------
  assign ch_wrap        = (channel_pos == CHW'(nc_eff - NCW'(1)));
  assign col_wrap       = (CW'(column_pos) + CW'(1) >= w_eff);
  assign row_wrap       = (CW'(row_pos) + CW'(1) >= h_eff);
  assign col_phase_wrap = (col_phase == f_last);
  assign row_phase_wrap = (row_phase == f_last);

  assign in_block   = (col_base + f_cw <= w_eff) && (row_base + f_cw <= h_eff);
  assign blk_first  = (col_phase == '0) && (row_phase == '0);
  assign blk_last   = col_phase_wrap && row_phase_wrap;
  assign frame_last = blk_last && ch_wrap &&
                      (col_base + (f_cw << 1) > w_eff) &&
                      (row_base + (f_cw << 1) > h_eff);
  assign addr0      = AW'(32'(block_col) * MAX_CHANNELS + 32'(channel_pos));

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      column_pos  <= '0;
      row_pos     <= '0;
      channel_pos <= '0;
      col_phase   <= '0;
      row_phase   <= '0;
      block_col   <= '0;
      col_base    <= '0;
      row_base    <= '0;
    end else if (accept) begin
      if (!ch_wrap) begin
        channel_pos <= channel_pos + CHW'(1);
      end else begin
        channel_pos <= '0;
        if (col_wrap) begin
          column_pos <= '0;
          col_phase  <= '0;
          block_col  <= '0;
          col_base   <= '0;
          if (row_wrap) begin
            row_pos   <= '0;
            row_phase <= '0;
            row_base  <= '0;
          end else begin
            row_pos <= row_pos + COLW'(1);
            if (row_phase_wrap) begin
              row_phase <= '0;
              row_base  <= row_base + f_cw;
            end else begin
              row_phase <= row_phase + XFW'(1);
            end
          end
        end else begin
          column_pos <= column_pos + COLW'(1);
          if (col_phase_wrap) begin
            col_phase <= '0;
            block_col <= block_col + COLW'(1);
            col_base  <= col_base + f_cw;
          end else begin
            col_phase <= col_phase + XFW'(1);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  assign s3_free       = !v3 || results.ready;
  assign s2_free       = !v2 || s3_free;
  assign s1_free       = !v1 || s2_free;
  assign s1_move       = v1 && s2_free;
  assign samples.ready = s1_free;
  assign accept        = samples.valid && s1_free;

  // stage 1: RAM read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_free) begin
      v1 <= accept && in_block;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      addr1   <= addr0;
      sample1 <= samples.sample;
      first1  <= blk_first;
      last1   <= blk_last;
      done1   <= frame_last;
    end
  end

  apd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (s1_move),
    .waddr (addr1),
    .wdata (sum1),
    .re    (accept && in_block),
    .raddr (addr0),
    .rdata (rd_data)
  );

  // the newest write may not be visible in the read data yet
  assign base = (lw_valid && (lw_addr == addr1)) ? lw_sum : rd_data;
  assign sum1 = first1 ? SUM_W'(sample1) : base + SUM_W'(sample1);

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (s1_move) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      lw_addr <= addr1;
      lw_sum  <= sum1;
    end
  end

  // stage 2: completed block sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_free) begin
      v2 <= s1_move && last1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      sum2  <= sum1;
      done2 <= done1;
    end
  end

  // stage 3: divide by factor squared via reciprocal multiply
  assign prod = PW'(sum2) * PW'(RECIP_TABLE[RECIP_IDX_W'(f_eff - FW'(1))]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (s3_free) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      avg3  <= prod[RECIP_SHIFT +: AVG_W];
      done3 <= done2;
    end
  end

  assign results.valid      = v3;
  assign results.average    = avg3;
  assign results.frame_done = done3;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (column_pos == '0 && row_pos == '0 && channel_pos == '0))
    else $error("position counters not cleared after config write");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (32'(col_phase) < 32'(f_eff)) && (32'(row_phase) < 32'(f_eff)))
    else $error("block phase outside pooling factor");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    32'(channel_pos) < 32'(nc_eff))
    else $error("channel position outside channel count");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (v1 && v2 && v3))
    else $error("input stalled with a free pipeline slot");

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the average pooling downsampler. A behavioral
// pooling predictor tracks geometry, positions and per-column sums, queues
// the expected averages and compares every result beat field by field.
// Directed frames cover register extremes, edge dropping, frame wrap and a
// long result stall; random frames with random idling follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import apd_pkg::*;

  localparam int          SUM_DEPTH    = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 150;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             frame_done;
  } pooled_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  apd_sample_if samples_if ();
  apd_result_if results_if ();

  average_pool_downsample_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .results   (results_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [WIDTH_REG_W-1:0]   width_reg  = RST_FRAME_WIDTH;
  logic [HEIGHT_REG_W-1:0]  height_reg = RST_FRAME_HEIGHT;
  logic [CHANNEL_REG_W-1:0] chans_reg  = RST_CHANNEL_COUNT;
  logic [FACTOR_REG_W-1:0]  factor_reg = RST_POOL_FACTOR;
  bit   [SUM_W-1:0]         col_sums [SUM_DEPTH];
  int unsigned              in_col  = 0;
  int unsigned              in_row  = 0;
  int unsigned              in_chan = 0;
  pooled_t                  expected_averages [$];

  int unsigned send_idle_pct  = 19;
  int unsigned recv_idle_pct  = 53;
  int unsigned hold_req       = 0;
  int unsigned hold_ack       = 0;
  int unsigned hold_left      = 0;
  int unsigned samples_sent   = 0;
  int unsigned results_seen   = 0;
  int unsigned geometries     = 0;
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;

  function automatic int unsigned effective(input int unsigned raw,
                                            input int unsigned ceiling);
    if (raw == 0) return 1;
    if (raw > ceiling) return ceiling;
    return raw;
  endfunction

  function automatic void pool_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned      w, h, nc, f, out_w, out_h, bx, by, slot;
    logic [SUM_W-1:0] sum;
    pooled_t          beat;
    w     = effective(32'(width_reg), DEF_MAX_WIDTH);
    h     = effective(32'(height_reg), DEF_MAX_WIDTH);
    nc    = effective(32'(chans_reg), DEF_MAX_CHANNELS);
    f     = effective(32'(factor_reg), DEF_MAX_FACTOR);
    out_w = w / f;
    out_h = h / f;
    bx    = in_col / f;
    by    = in_row / f;
    if (bx < out_w && by < out_h && in_chan < nc) begin
      slot = (bx * DEF_MAX_CHANNELS + in_chan) % SUM_DEPTH;
      // first sample of a block restarts its sum
      if (in_col % f == 0 && in_row % f == 0) begin
        sum = SUM_W'(value);
      end else begin
        sum = col_sums[slot] + SUM_W'(value);
      end
      col_sums[slot] = sum;
      if (in_col % f == f - 1 && in_row % f == f - 1) begin
        beat.average    = AVG_W'(sum / (f * f));
        beat.frame_done = (bx == out_w - 1 && by == out_h - 1 && in_chan == nc - 1);
        expected_averages.push_back(beat);
      end
    end
    in_chan++;
    if (in_chan >= nc) begin
      in_chan = 0;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.sample <= value;
    do @(posedge clk); while (!samples_if.ready);
    pool_sample(value);
    samples_sent++;
  endtask

  // drop valid, wait for every expected beat, then let silent samples retire
  task automatic wait_drained();
    samples_if.valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:   width_reg  = value[WIDTH_REG_W-1:0];
      REG_FRAME_HEIGHT:  height_reg = value[HEIGHT_REG_W-1:0];
      REG_CHANNEL_COUNT: chans_reg  = value[CHANNEL_REG_W-1:0];
      REG_POOL_FACTOR:   factor_reg = value[FACTOR_REG_W-1:0];
      default: ;
    endcase
    in_col  = 0;
    in_row  = 0;
    in_chan = 0;
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, h, nc, f);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, nc);
    write_reg(REG_POOL_FACTOR, f);
    cfg_write <= 1'b0;
    geometries++;
  endtask

  // default geometry: first row of a 2x pooled frame gives nothing
  task automatic test_reset_defaults();
    int unsigned i;
    for (i = 0; i < 12; i++) send_sample(pick_sample());
    wait_drained();
  endtask

  // zero registers act as one: every sample is its own frame
  task automatic test_zero_registers();
    set_geometry('0, '0, '0, '0);
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(8'h55);
    send_sample(8'hAA);
    send_sample(8'h80);
    wait_drained();
  endtask

  task automatic test_truncation();
    set_geometry(2, 2, 1, 2);
    send_sample(8'd1);
    send_sample(8'd0);
    send_sample(8'd0);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd255);
    send_sample(8'd255);
    send_sample(8'd254);
    wait_drained();
  endtask

  // last column and row fill no block; two frames back to back
  task automatic test_dropped_edges();
    int unsigned i;
    set_geometry(5, 3, 2, 2);
    for (i = 0; i < 60; i++) send_sample(pick_sample());
    wait_drained();
  endtask

  task automatic test_factor_beyond_frame();
    int unsigned i;
    set_geometry(3, 3, 1, 4);
    for (i = 0; i < 18; i++) send_sample(pick_sample());
    wait_drained();
  endtask

  // factor 31 saturates to 16, channel 9 masks to 1: one full-scale block
  task automatic test_largest_block();
    int unsigned i;
    set_geometry(16, 16, 9, 13'h1FFF);
    for (i = 0; i < 16 * 16; i++) send_sample(8'hFF);
    wait_drained();
  endtask

  task automatic test_saturated_registers();
    int unsigned i;
    set_geometry(2, 13'h1FFF, 13'h1FFF, 1);
    for (i = 0; i < 24; i++) send_sample(pick_sample());
    wait_drained();
  endtask

  // long result stall while samples keep coming: input must back up
  task automatic test_back_pressure();
    int unsigned i;
    send_idle_pct = 0;
    set_geometry(6, 2, 1, 1);
    hold_req++;
    for (i = 0; i < 24; i++) send_sample(pick_sample());
    wait_drained();
  endtask

  task automatic test_random_frames(input int unsigned sender_pct,
                                    input int unsigned receiver_pct,
                                    input int unsigned quota);
    int unsigned first, w, h, nc, f, frame_len, count, i;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    first = samples_sent;
    while (samples_sent - first < quota) begin
      w  = $urandom_range(6, 1);
      h  = $urandom_range(6, 1);
      nc = $urandom_range(4, 1);
      f  = ($urandom_range(9) == 0) ? $urandom_range(16, 1) : $urandom_range(3, 1);
      set_geometry(CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(nc), CFG_DATA_W'(f));
      frame_len = w * h * nc;
      case ($urandom_range(9))
        0:       count = $urandom_range(frame_len - 1);       // cut short
        1:       count = frame_len + $urandom_range(frame_len); // wrap
        default: count = frame_len;
      endcase
      for (i = 0; i < count; i++) send_sample(pick_sample());
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      results_if.ready <= 1'b0;
      hold_left        <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      results_if.ready <= 1'b0;
      hold_left        <= HOLD_CYCLES - 1;
      hold_ack         <= hold_req;
    end else begin
      results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pooled_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_averages.size() == 0) begin
        report_mismatch("unexpected result beat, average", 32'(results_if.average), 0);
      end else begin
        want = expected_averages.pop_front();
        if (results_if.average !== want.average)
          report_mismatch("average", 32'(results_if.average), 32'(want.average));
        if (results_if.frame_done !== want.frame_done)
          report_mismatch("frame_done", 32'(results_if.frame_done),
                          32'(want.frame_done));
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no beat for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = REG_FRAME_WIDTH;
    cfg_data          = '0;
    samples_if.valid  = 1'b0;
    samples_if.sample = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_zero_registers();
    test_truncation();
    test_dropped_edges();
    test_factor_beyond_frame();
    test_largest_block();
    test_saturated_registers();
    test_back_pressure();
    test_random_frames(19, 53, 12);
    test_random_frames(53, 19, 12);
    test_random_frames(0, 0, 12);

    if (expected_averages.size() != 0)
      report_mismatch("results never delivered", 0, expected_averages.size());
    $display("Run covered %0d samples and %0d pooled results over %0d geometries,",
             samples_sent, results_seen, geometries);
    $display("including register extremes, edge dropping, frame wrap and a long stall.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: average_pool_downsample_core.f
rtl/apd_pkg.sv
rtl/apd_stream_if.sv
rtl/apd_ram.sv
rtl/average_pool_downsample_core.sv
test/testbench.sv
